>>> hw/rtl/hfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfd_pkg: shared types and constants of the HTTP/2 frame deframer
// Word layouts of both channels, deframer state, frame type and flag codes.
// ----------------------------------------------------------------------------
package hfd_pkg;

	// Frame types
	localparam logic [7:0] FT_DATA    = 8'h00;
	localparam logic [7:0] FT_HEADERS = 8'h01;
	localparam logic [7:0] FT_CONT    = 8'h09;

	// Frame flags
	localparam logic [7:0] FL_END_STREAM  = 8'h01;
	localparam logic [7:0] FL_END_HEADERS = 8'h04;
	localparam logic [7:0] FL_PADDED      = 8'h08;
	localparam logic [7:0] FL_PRIORITY    = 8'h20;

	localparam logic [3:0]  HDR_BYTES        = 4'd9;
	localparam logic [15:0] MAX_BUFFER_BYTES = 16'd65535;
	localparam logic [2:0]  PRIO_BYTES       = 3'd5;

	// Payload byte kinds
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_HBLOCK = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;

	// Buffer status
	localparam logic [1:0] ST_RUNNING   = 2'd0;
	localparam logic [1:0] ST_COMPLETE  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_OVERRUN   = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  out_kind;
		logic [7:0]  cur_frame_type;
		logic [7:0]  cur_frame_flags;
		logic        frame_end;
		logic [1:0]  status;
		logic        headers_done;
		logic        stream_done;
		logic [15:0] bytes_used;
	} out_word_t;

	typedef struct packed {
		logic [3:0]  header_pos;
		logic [23:0] frm_len;
		logic [7:0]  frame_kind;
		logic [7:0]  frame_flag_bits;
		logic [23:0] payload_pos;
		logic [7:0]  pad_count;
		logic        headers_seen;
		logic        stream_end_seen;
		logic        finished;
		logic        failed;
		logic        frame_bad;
		logic [15:0] byte_count;
	} dfr_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/hfd_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfd_step: per-byte deframer update
// Next state and result word for one input byte, given the current state.
// ----------------------------------------------------------------------------
module hfd_step (
	input  hfd_pkg::dfr_state_t cur,
	input  hfd_pkg::in_word_t   word,
	output hfd_pkg::dfr_state_t nxt,
	output hfd_pkg::out_word_t  res
);
	import hfd_pkg::*;

	function automatic logic pad_applies(input logic [7:0] kind, input logic [7:0] flags);
		pad_applies = ((kind == FT_DATA) || (kind == FT_HEADERS)) && ((flags & FL_PADDED) != 8'h00);
	endfunction

	function automatic logic prio_applies(input logic [7:0] kind, input logic [7:0] flags);
		prio_applies = (kind == FT_HEADERS) && ((flags & FL_PRIORITY) != 8'h00);
	endfunction

	// Fold a finished frame's END flags into the stream state, or mark the buffer failed if the frame was bad.
	function automatic dfr_state_t close_frame(input dfr_state_t s);
		dfr_state_t t;
		t = s;
		t.header_pos = 4'd0;
		if (s.frame_bad) begin
			t.failed = 1'b1;
		end else begin
			if (s.frame_kind == FT_HEADERS) begin
				if ((s.frame_flag_bits & FL_END_HEADERS) != 8'h00) t.headers_seen = 1'b1;
				if ((s.frame_flag_bits & FL_END_STREAM) != 8'h00) t.stream_end_seen = 1'b1;
			end else if (s.frame_kind == FT_DATA) begin
				if ((s.frame_flag_bits & FL_END_STREAM) != 8'h00) t.stream_end_seen = 1'b1;
			end else if (s.frame_kind == FT_CONT) begin
				if ((s.frame_flag_bits & FL_END_HEADERS) != 8'h00) t.headers_seen = 1'b1;
			end
			if (t.headers_seen && t.stream_end_seen) t.finished = 1'b1;
		end
		close_frame = t;
	endfunction

	logic [7:0]  b;
	logic        padded;
	logic        prio;
	logic [8:0]  need;
	logic [2:0]  start;
	logic [23:0] stop;
	logic [23:0] p;
	logic [7:0]  pad_nxt;
	logic        bad;

	assign b = word.in_byte;

	always_comb begin
		nxt     = cur;
		res     = '0;
		padded  = 1'b0;
		prio    = 1'b0;
		need    = '0;
		start   = '0;
		stop    = '0;
		p       = cur.payload_pos;
		pad_nxt = cur.pad_count;
		bad     = cur.frame_bad;

		if (!cur.finished && !cur.failed) begin
			if (cur.byte_count < MAX_BUFFER_BYTES) nxt.byte_count = cur.byte_count + 16'd1;
			if (cur.header_pos < HDR_BYTES) begin
				case (cur.header_pos)
					4'd0: begin
						nxt.frm_len         = {b, 16'h0000};
						nxt.frame_kind      = 8'h00;
						nxt.frame_flag_bits = 8'h00;
					end
					4'd1: nxt.frm_len = cur.frm_len | {8'h00, b, 8'h00};
					4'd2: nxt.frm_len = cur.frm_len | {16'h0000, b};
					4'd3: nxt.frame_kind = b;
					4'd4: nxt.frame_flag_bits = b;
					default: ;  // stream id bytes: drop
				endcase
				nxt.header_pos      = cur.header_pos + 4'd1;
				res.cur_frame_type  = nxt.frame_kind;
				res.cur_frame_flags = nxt.frame_flag_bits;
				if (nxt.header_pos == HDR_BYTES) begin
					padded          = pad_applies(nxt.frame_kind, nxt.frame_flag_bits);
					prio            = prio_applies(nxt.frame_kind, nxt.frame_flag_bits);
					nxt.payload_pos = '0;
					nxt.pad_count   = '0;
					nxt.frame_bad   = (padded && (nxt.frm_len == 24'd0)) ||
						(!padded && prio && (nxt.frm_len < {21'd0, PRIO_BYTES}));
					if (nxt.frm_len == 24'd0) begin
						res.frame_end = 1'b1;
						nxt           = close_frame(nxt);
					end
				end
			end else begin
				padded              = pad_applies(cur.frame_kind, cur.frame_flag_bits);
				prio                = prio_applies(cur.frame_kind, cur.frame_flag_bits);
				res.cur_frame_type  = cur.frame_kind;
				res.cur_frame_flags = cur.frame_flag_bits;
				if (padded && (p == 24'd0)) begin
					pad_nxt = b;
					need    = 9'd1 + {1'b0, b} + (prio ? {6'd0, PRIO_BYTES} : 9'd0);
					if ({15'd0, need} > cur.frm_len) bad = 1'b1;
				end
				nxt.pad_count = pad_nxt;
				nxt.frame_bad = bad;
				if (!bad) begin
					if (cur.frame_kind == FT_CONT) begin
						res.out_kind = KIND_HBLOCK;
					end else if ((cur.frame_kind == FT_HEADERS) || (cur.frame_kind == FT_DATA)) begin
						start = (padded ? 3'd1 : 3'd0) + (prio ? PRIO_BYTES : 3'd0);
						stop  = cur.frm_len - (padded ? {16'd0, pad_nxt} : 24'd0);
						if ((p >= {21'd0, start}) && (p < stop))
							res.out_kind = (cur.frame_kind == FT_HEADERS) ? KIND_HBLOCK : KIND_DATA;
					end
					if (res.out_kind != KIND_NONE) res.out_byte = b;
				end
				nxt.payload_pos = p + 24'd1;
				if (nxt.payload_pos == cur.frm_len) begin
					res.frame_end = 1'b1;
					nxt           = close_frame(nxt);
				end
			end
		end

		res.headers_done = nxt.headers_seen;
		res.stream_done  = nxt.stream_end_seen;

		if (word.end_of_buffer) begin
			if (nxt.finished) res.status = ST_COMPLETE;
			else if (nxt.failed) res.status = ST_OVERRUN;
			else if (nxt.header_pos != 4'd0) res.status = ST_TRUNCATED;
			else res.status = nxt.headers_seen ? ST_COMPLETE : ST_TRUNCATED;
			if (res.status == ST_COMPLETE) res.bytes_used = nxt.byte_count;
			// next byte opens a new buffer
			nxt = '0;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/http2_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http2_frame_deframer: HTTP/2 frame splitter, one byte per word
// Strips frame headers, padding and priority fields and tags payload bytes.
// ----------------------------------------------------------------------------
// Each input word carries one byte of a received buffer and yields exactly one
// result word. Throughput is one word per clock while out_ready holds: a byte
// is registered on input, runs through the combinational state update, and
// lands in the result register, which drives out_valid. The result register
// frees in the same cycle it is taken, and while a result waits the input
// register still takes one more word, so back-pressure stalls the input only
// once both registers are full.
// Status, headers_done, stream_done and bytes_used describe the buffer on the
// word that carries end_of_buffer; state then returns to reset for the next
// buffer.
module http2_frame_deframer (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  hfd_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output hfd_pkg::out_word_t out_data
);
	import hfd_pkg::*;

	in_word_t   word_s1;
	logic       vld_s1;
	dfr_state_t state_q;
	dfr_state_t state_nxt;
	out_word_t  res;
	out_word_t  out_q;
	logic       out_vld_q;
	logic       advance;

	// Move the held byte forward when the result slot is empty or being taken.
	assign advance  = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	hfd_step u_step (
		.cur  (state_q),
		.word (word_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			state_q   <= '0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (advance) begin
				state_q   <= state_nxt;
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) word_s1 <= in_data;
		if (advance) out_q <= res;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
